FILE: rtl/mhpq_pkg.sv
// Shared types and constants for the max-heap priority queue.
// No dependencies; every other file refers to this package by scoped names.
package mhpq_pkg;

  // Field widths of the request and response beats
  localparam int unsigned DataW   = 32;
  localparam int unsigned OpW     = 2;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CountW  = 7;

  // Default number of entries (at most 127, so that a count fits in CountW bits)
  localparam int unsigned Capacity = 64;

  // Request codes
  typedef enum logic [OpW-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_PEEK   = 2'd2,
    OP_SORT   = 2'd3
  } op_e;

  // Response status codes
  typedef enum logic [StatusW-1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_EMPTY    = 2'd2
  } status_e;

  // Command broadcast to every cell of the chain
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,     // open a gap and drop the new value into it
    CELL_SHIFT_UP,   // take the neighbour further from the root
    CELL_SHIFT_DOWN  // take the neighbour nearer the root
  } cell_cmd_e;

  typedef struct packed {
    cell_cmd_e                cmd;
    logic signed [DataW-1:0] data;
  } cell_ctrl_t;

  // Contents of one cell as seen by its neighbours
  typedef struct packed {
    logic                     ok;
    logic signed [DataW-1:0] value;
  } cell_slot_t;

endpackage

FILE: rtl/mhpq_req_if.sv
// Request channel of the priority queue: valid/ready with op and data.
// Depends on mhpq_pkg.
interface mhpq_req_if;
  logic                              valid;
  logic                              ready;
  mhpq_pkg::op_e                     op;
  logic signed [mhpq_pkg::DataW-1:0] data;

  modport source (output valid, op, data, input ready);
  modport sink   (input valid, op, data, output ready);
endinterface

FILE: rtl/mhpq_rsp_if.sv
// Response channel of the priority queue: valid/ready with result fields.
// Depends on mhpq_pkg.
interface mhpq_rsp_if;
  logic                              valid;
  logic                              ready;
  logic signed [mhpq_pkg::DataW-1:0] value;
  mhpq_pkg::status_e                 status;
  logic [mhpq_pkg::CountW-1:0]       count;
  logic                              last;

  modport source (output valid, value, status, count, last, input ready);
  modport sink   (input valid, value, status, count, last, output ready);
endinterface

FILE: rtl/mhpq_cell.sv
// One cell of the sorted chain: holds one value and its occupied flag.
// Depends on mhpq_pkg; instantiated in a row by max_heap_priority_queue_core.
module mhpq_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mhpq_pkg::cell_ctrl_t ctrl_i,
  input  mhpq_pkg::cell_slot_t left_i,     // neighbour nearer the root
  input  logic                 left_gt_i,  // new value belongs before the left cell
  input  mhpq_pkg::cell_slot_t right_i,    // neighbour further from the root
  output mhpq_pkg::cell_slot_t slot_o,
  output logic                 gt_o
);

  mhpq_pkg::cell_slot_t slot_q, slot_d;

  // New value ranks before this cell when the cell is empty or smaller
  assign gt_o   = !slot_q.ok || (ctrl_i.data > slot_q.value);
  assign slot_o = slot_q;

  // Pick the next contents from the command
  always_comb begin
    slot_d = slot_q;
    unique case (ctrl_i.cmd)
      mhpq_pkg::CELL_HOLD: slot_d = slot_q;
      mhpq_pkg::CELL_INSERT: begin
        if (gt_o) begin
          if (left_gt_i) begin
            slot_d = left_i;
          end else begin
            slot_d.ok    = 1'b1;
            slot_d.value = ctrl_i.data;
          end
        end
      end
      mhpq_pkg::CELL_SHIFT_UP:   slot_d = right_i;
      mhpq_pkg::CELL_SHIFT_DOWN: slot_d = left_i;
      default:                   slot_d = slot_q;
    endcase
  end

  // Hold the cell contents
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q.ok    <= 1'b0;
      slot_q.value <= '0;
    end else begin
      slot_q <= slot_d;
    end
  end

endmodule

FILE: rtl/max_heap_priority_queue_core.sv
// Max priority queue of signed 32-bit values, kept as a chain of CAPACITY
// cells sorted largest first with the largest at the head. For insert,
// delete and peek, a beat is accepted whenever the block is idle and the
// response register is free or being taken, and the response follows in
// the next cycle. Sort shifts the whole chain one place per cycle toward
// the tail, except while a tail value waits on a full response register,
// and emits each value as it leaves the tail cell, smallest first; the
// chain is empty afterwards. Depends on mhpq_pkg, mhpq_req_if,
// mhpq_rsp_if and mhpq_cell.
module max_heap_priority_queue_core #(
  parameter int unsigned CAPACITY = mhpq_pkg::Capacity
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mhpq_req_if.sink    req_i,
  mhpq_rsp_if.source  rsp_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  typedef enum logic {
    S_IDLE,
    S_SORT
  } state_e;

  state_e                             state_q;
  logic [CntW-1:0]                    count_q;
  logic                               out_valid_q;
  logic signed [mhpq_pkg::DataW-1:0]  out_value_q;
  mhpq_pkg::status_e                  out_status_q;
  logic [mhpq_pkg::CountW-1:0]        out_count_q;
  logic                               out_last_q;

  mhpq_pkg::cell_ctrl_t ctrl;
  mhpq_pkg::cell_slot_t slot [CAPACITY];
  logic                 gt   [CAPACITY];

  logic out_free;
  logic accept;
  logic full;
  logic empty;
  logic emit;
  mhpq_pkg::cell_slot_t tail;

  assign tail     = slot[CAPACITY-1];
  assign full     = (count_q == CntW'(CAPACITY));
  assign empty    = (count_q == '0);
  assign out_free = !out_valid_q || rsp_o.ready;
  assign accept   = req_i.valid && req_i.ready;
  assign emit     = (state_q == S_SORT) && tail.ok && out_free;

  assign req_i.ready  = (state_q == S_IDLE) && out_free;
  assign rsp_o.valid  = out_valid_q;
  assign rsp_o.value  = out_value_q;
  assign rsp_o.status = out_status_q;
  assign rsp_o.count  = out_count_q;
  assign rsp_o.last   = out_last_q;

  // Decode the chain command
  always_comb begin
    ctrl.cmd  = mhpq_pkg::CELL_HOLD;
    ctrl.data = req_i.data;
    if (accept) begin
      unique case (req_i.op)
        mhpq_pkg::OP_INSERT: if (!full) ctrl.cmd = mhpq_pkg::CELL_INSERT;
        mhpq_pkg::OP_DELETE: if (!empty) ctrl.cmd = mhpq_pkg::CELL_SHIFT_UP;
        mhpq_pkg::OP_PEEK:   ctrl.cmd = mhpq_pkg::CELL_HOLD;
        mhpq_pkg::OP_SORT:   ctrl.cmd = mhpq_pkg::CELL_HOLD;
        default:             ctrl.cmd = mhpq_pkg::CELL_HOLD;
      endcase
    end else if (state_q == S_SORT) begin
      // advance toward the tail unless a value waits on a full response slot
      if (!tail.ok || out_free) ctrl.cmd = mhpq_pkg::CELL_SHIFT_DOWN;
    end
  end

  // Row of cells, head at index 0
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    mhpq_pkg::cell_slot_t left, right;
    logic                 left_gt;
    if (i == 0) begin : g_head
      assign left    = '0;
      assign left_gt = 1'b0;
    end else begin : g_body
      assign left    = slot[i-1];
      assign left_gt = gt[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign right = '0;
    end else begin : g_inner
      assign right = slot[i+1];
    end
    mhpq_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .left_i    (left),
      .left_gt_i (left_gt),
      .right_i   (right),
      .slot_o    (slot[i]),
      .gt_o      (gt[i])
    );
  end

  // Hold state, fill count and the response register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      out_valid_q  <= 1'b0;
      out_value_q  <= '0;
      out_status_q <= mhpq_pkg::ST_OK;
      out_count_q  <= '0;
      out_last_q   <= 1'b0;
    end else begin
      if (accept) begin
        out_valid_q <= 1'b1;
        out_last_q  <= 1'b1;
        out_value_q <= '0;
        unique case (req_i.op)
          mhpq_pkg::OP_INSERT: begin
            if (full) begin
              out_status_q <= mhpq_pkg::ST_OVERFLOW;
              out_count_q  <= mhpq_pkg::CountW'(count_q);
            end else begin
              count_q      <= count_q + CntW'(1);
              out_status_q <= mhpq_pkg::ST_OK;
              out_count_q  <= mhpq_pkg::CountW'(count_q + CntW'(1));
            end
          end
          mhpq_pkg::OP_DELETE: begin
            if (empty) begin
              out_status_q <= mhpq_pkg::ST_EMPTY;
              out_count_q  <= '0;
            end else begin
              count_q      <= count_q - CntW'(1);
              out_status_q <= mhpq_pkg::ST_OK;
              out_count_q  <= mhpq_pkg::CountW'(count_q - CntW'(1));
            end
          end
          mhpq_pkg::OP_PEEK: begin
            out_count_q <= mhpq_pkg::CountW'(count_q);
            if (empty) begin
              out_value_q  <= '1;
              out_status_q <= mhpq_pkg::ST_EMPTY;
            end else begin
              out_value_q  <= slot[0].value;
              out_status_q <= mhpq_pkg::ST_OK;
            end
          end
          mhpq_pkg::OP_SORT: begin
            out_count_q <= '0;
            if (empty) begin
              out_status_q <= mhpq_pkg::ST_EMPTY;
            end else begin
              // count_q now tracks the values still to be emitted
              out_valid_q <= 1'b0;
              state_q     <= S_SORT;
            end
          end
          default: out_status_q <= mhpq_pkg::ST_OK;
        endcase
      end else if (emit) begin
        // drop the tail value into the response register
        out_valid_q  <= 1'b1;
        out_value_q  <= tail.value;
        out_status_q <= mhpq_pkg::ST_OK;
        out_count_q  <= '0;
        out_last_q   <= (count_q == CntW'(1));
        count_q      <= count_q - CntW'(1);
        if (count_q == CntW'(1)) state_q <= S_IDLE;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule
